[hdl/pali_pkg.sv]
package pali_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int LEN_W      = 40;
	localparam int SEG_W      = 33;
	localparam int RAD_W      = 66;
	localparam int REM_W      = 35;
	localparam int QUO_W      = 17;
	localparam int NUM_W      = SEG_W + 16;
	localparam int LST_W      = LEN_W + 4;
	localparam int T_W        = 17;
	localparam int PROD_W     = LEN_W + T_W;
	localparam int MUL_W      = 34;
	localparam int SQRT_STEPS = 33;
	localparam int DIV_STEPS  = QUO_W;

	localparam logic [15:0]    TOL_RESET = 16'd655;
	localparam logic [T_W-1:0] T_ONE     = 17'd65536;

	localparam logic [1:0] REG_DEFAULT_X = 2'd0;
	localparam logic [1:0] REG_DEFAULT_Y = 2'd1;
	localparam logic [1:0] REG_DEFAULT_Z = 2'd2;
	localparam logic [1:0] REG_TOLERANCE = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		SC_OK      = 3'd0,
		SC_FEW     = 3'd1,
		SC_ZERO    = 3'd2,
		SC_FULL    = 3'd3,
		SC_NOMATCH = 3'd4
	} status_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [17:0] t;
	} item_t;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic [15:0]        tol;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] tan_x;
		logic signed [15:0] tan_y;
		logic signed [15:0] tan_z;
		status_t            status;
		logic [6:0]         point_total;
		logic [LEN_W-1:0]   path_length;
	} result_t;

endpackage

[hdl/polyline_arc_length_interpolator.sv]
// Channel   Direction  Content
// s_*       in         tuser: operation; tdata: point_x, point_y, point_z, t_param
// m_*       out        tuser: status; tdata: position, tangent, point_total, path_length
// cfg_*     in         cfg_index selects default_x, default_y, default_z, match_tolerance
//
// An add after the first point uses the 33-step square root unit for the new segment.
// A query scales the path length by t, then walks the segments through the square root
// unit, then uses the 17-step shared divider for the fraction and each tangent component.
// Reset is asynchronous; the vertex memory is not cleared and holds nothing until written.
// A result waits in the output register, so the next transfer is taken while it stalls.
module polyline_arc_length_interpolator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [119:0]  s_tdata,   // point_x, point_y, point_z, t_param, zero pad
	input  logic [1:0]    s_tuser,   // operation
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [191:0]  m_tdata,   // pos_x/y/z, tan_x/y/z, point_total, path_length, pad
	output logic [2:0]    m_tuser,   // status
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	pali_pkg::cfg_t    cfg_q;
	pali_pkg::item_t   item;
	pali_pkg::result_t core_res;
	pali_pkg::result_t res_q;
	logic              core_valid;
	logic              core_ready;
	logic              m_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dx  <= '0;
			cfg_q.dy  <= '0;
			cfg_q.dz  <= '0;
			cfg_q.tol <= pali_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				pali_pkg::REG_DEFAULT_X: cfg_q.dx  <= cfg_data;
				pali_pkg::REG_DEFAULT_Y: cfg_q.dy  <= cfg_data;
				pali_pkg::REG_DEFAULT_Z: cfg_q.dz  <= cfg_data;
				pali_pkg::REG_TOLERANCE: cfg_q.tol <= cfg_data[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign item.op = pali_pkg::op_t'(s_tuser);
	assign item.px = s_tdata[31:0];
	assign item.py = s_tdata[63:32];
	assign item.pz = s_tdata[95:64];
	assign item.t  = s_tdata[113:96];

	pali_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.cfg       (cfg_q),
		.out_valid (core_valid),
		.out_ready (core_ready),
		.out_res   (core_res)
	);

	assign core_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (core_ready) begin
			m_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {1'b0, res_q.path_length, res_q.point_total,
	                   res_q.tan_z, res_q.tan_y, res_q.tan_x,
	                   res_q.pos_z, res_q.pos_y, res_q.pos_x};

endmodule

[hdl/pali_sqrt.sv]
module pali_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pali_pkg::RAD_W-1:0]     radicand,
	output logic                           done,
	output logic [pali_pkg::SEG_W-1:0]     root
);

	logic                          busy_q;
	logic                          done_q;
	logic [5:0]                    cnt_q;
	logic [pali_pkg::RAD_W-1:0]    rad_q;
	logic [pali_pkg::REM_W-1:0]    rem_q;
	logic [pali_pkg::SEG_W-1:0]    root_q;
	logic [pali_pkg::REM_W+1:0]    cur;
	logic [pali_pkg::REM_W+1:0]    trial;
	logic                          fits;

	assign cur   = {rem_q, rad_q[pali_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(pali_pkg::SQRT_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[pali_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? pali_pkg::REM_W'(cur - trial) : cur[pali_pkg::REM_W-1:0];
			root_q <= {root_q[pali_pkg::SEG_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[hdl/pali_div.sv]
module pali_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pali_pkg::NUM_W-1:0]     dividend,
	input  logic [pali_pkg::SEG_W-1:0]     divisor,
	output logic                           done,
	output logic [pali_pkg::QUO_W-1:0]     quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [4:0]                    cnt_q;
	logic [pali_pkg::SEG_W-1:0]    rem_q;
	logic [pali_pkg::SEG_W-1:0]    den_q;
	logic [pali_pkg::QUO_W-1:0]    low_q;
	logic [pali_pkg::QUO_W-1:0]    quo_q;
	logic [pali_pkg::SEG_W:0]      cur;
	logic                          fits;

	assign cur  = {rem_q, low_q[pali_pkg::QUO_W-1]};
	assign fits = (cur >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(pali_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= pali_pkg::SEG_W'(dividend[pali_pkg::NUM_W-1:pali_pkg::QUO_W]);
			low_q <= dividend[pali_pkg::QUO_W-1:0];
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? pali_pkg::SEG_W'(cur - {1'b0, den_q}) : cur[pali_pkg::SEG_W-1:0];
			low_q <= {low_q[pali_pkg::QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[pali_pkg::QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/pali_core.sv]
module pali_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pali_pkg::item_t   in_item,
	input  pali_pkg::cfg_t    cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output pali_pkg::result_t out_res
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_TGT,
		S_RDA_W,
		S_RDA,
		S_RDB_W,
		S_RDB,
		S_SQ,
		S_SQRT_GO,
		S_SQRT_W,
		S_ADDLEN,
		S_CHECK,
		S_DIV_GO,
		S_DIV_W,
		S_LERP,
		S_TAN_GO,
		S_TAN_W,
		S_DONE
	} state_t;

	state_t                           state_q;
	pali_pkg::op_t                    op_q;
	pali_pkg::status_t                status_q;
	logic [2:0][31:0]                 a_q;
	logic [2:0][31:0]                 b_q;
	logic [2:0][31:0]                 last_q;
	logic [2:0][31:0]                 pos_q;
	logic [2:0][15:0]                 tan_q;
	logic [1:0]                       k_q;
	logic [pali_pkg::CNT_W-1:0]       count_q;
	logic [pali_pkg::IDX_W-1:0]       idx_q;
	logic [pali_pkg::LEN_W-1:0]       total_q;
	logic [pali_pkg::RAD_W-1:0]       acc_q;
	logic [pali_pkg::SEG_W-1:0]       len_q;
	logic [pali_pkg::PROD_W-1:0]      tgt_q;
	logic [pali_pkg::PROD_W-1:0]      mcand_q;
	logic [pali_pkg::T_W-1:0]         tmul_q;
	logic [4:0]                       cnt_q;
	logic [pali_pkg::LST_W-1:0]       lst_q;
	logic [pali_pkg::T_W-1:0]         part_q;

	logic [95:0]                      vtx_q [pali_pkg::MAX_POINTS];
	logic [95:0]                      rd_q;
	logic                             wr_en;

	logic [pali_pkg::SEG_W-1:0]       d;
	logic [pali_pkg::SEG_W-1:0]       mag;
	logic signed [pali_pkg::MUL_W-1:0] mul_a;
	logic signed [pali_pkg::MUL_W-1:0] mul_b;
	logic signed [2*pali_pkg::MUL_W-1:0] prod;
	logic signed [2*pali_pkg::MUL_W-1:0] rnd;
	logic [pali_pkg::LEN_W-1:0]       target;
	logic [pali_pkg::LST_W-1:0]       reach;
	logic [pali_pkg::LST_W-1:0]       num;
	logic [pali_pkg::LEN_W:0]         sum_len;
	logic [pali_pkg::T_W-1:0]         tclamp;
	logic                             sqrt_done;
	logic [pali_pkg::SEG_W-1:0]       sqrt_root;
	logic                             div_start;
	logic [pali_pkg::NUM_W-1:0]       div_n;
	logic                             div_done;
	logic [pali_pkg::QUO_W-1:0]       div_q;
	logic [16:0]                      neg_val;
	logic [15:0]                      tan_val;

	assign d     = {b_q[k_q][31], b_q[k_q]} - {a_q[k_q][31], a_q[k_q]};
	assign mag   = d[pali_pkg::SEG_W-1] ? pali_pkg::SEG_W'(-d) : d;
	assign mul_a = {d[pali_pkg::SEG_W-1], d};
	assign mul_b = (state_q == S_LERP) ? pali_pkg::MUL_W'({1'b0, part_q})
	                                   : {d[pali_pkg::SEG_W-1], d};
	assign prod  = mul_a * mul_b;
	assign rnd   = (prod + 68'sd32768) >>> 16;

	assign target  = tgt_q[pali_pkg::LEN_W+15:16];
	assign reach   = lst_q + pali_pkg::LST_W'(len_q) + pali_pkg::LST_W'(cfg.tol);
	assign num     = (pali_pkg::LST_W'(target) > lst_q) ? pali_pkg::LST_W'(target) - lst_q : '0;
	assign sum_len = {1'b0, total_q} + (pali_pkg::LEN_W+1)'(len_q);

	always_comb begin
		if (in_item.t[17]) begin
			tclamp = '0;
		end else if (in_item.t[16:0] > pali_pkg::T_ONE) begin
			tclamp = pali_pkg::T_ONE;
		end else begin
			tclamp = in_item.t[16:0];
		end
	end

	assign div_start = (state_q == S_DIV_GO) || (state_q == S_TAN_GO);
	assign div_n     = (state_q == S_DIV_GO)
		? {num[pali_pkg::SEG_W-1:0], 16'd0}
		: pali_pkg::NUM_W'({mag, 15'd0}) + pali_pkg::NUM_W'(len_q >> 1);

	assign neg_val = 17'(-div_q);
	always_comb begin
		if (d[pali_pkg::SEG_W-1]) begin
			tan_val = (div_q > 17'd32768) ? 16'h8000 : neg_val[15:0];
		end else begin
			tan_val = (div_q > 17'd32767) ? 16'h7FFF : div_q[15:0];
		end
	end

	pali_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SQRT_GO),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	pali_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign wr_en = (state_q == S_IDLE) && in_valid && (in_item.op == pali_pkg::OP_ADD)
		&& (count_q < pali_pkg::CNT_W'(pali_pkg::MAX_POINTS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vtx_q[count_q[pali_pkg::IDX_W-1:0]] <= {in_item.pz, in_item.py, in_item.px};
		end
		rd_q <= vtx_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= pali_pkg::OP_NONE;
			status_q <= pali_pkg::SC_OK;
			a_q      <= '0;
			b_q      <= '0;
			last_q   <= '0;
			pos_q    <= '0;
			tan_q    <= '0;
			k_q      <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			total_q  <= '0;
			acc_q    <= '0;
			len_q    <= '0;
			tgt_q    <= '0;
			mcand_q  <= '0;
			tmul_q   <= '0;
			cnt_q    <= '0;
			lst_q    <= '0;
			part_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_item.op;
						status_q <= pali_pkg::SC_OK;
						pos_q    <= {cfg.dz, cfg.dy, cfg.dx};
						tan_q    <= '0;
						state_q  <= S_DONE;
						case (in_item.op)
							pali_pkg::OP_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							pali_pkg::OP_ADD: begin
								if (!wr_en) begin
									status_q <= pali_pkg::SC_FULL;
								end else begin
									a_q     <= last_q;
									b_q     <= {in_item.pz, in_item.py, in_item.px};
									last_q  <= {in_item.pz, in_item.py, in_item.px};
									count_q <= count_q + 1'b1;
									if (count_q != '0) begin
										k_q     <= '0;
										acc_q   <= '0;
										state_q <= S_SQ;
									end
								end
							end
							pali_pkg::OP_QUERY: begin
								if (count_q < pali_pkg::CNT_W'(2)) begin
									status_q <= pali_pkg::SC_FEW;
								end else begin
									tmul_q  <= tclamp;
									mcand_q <= pali_pkg::PROD_W'(total_q);
									tgt_q   <= '0;
									cnt_q   <= '0;
									state_q <= S_TGT;
								end
							end
							default: begin
								status_q <= pali_pkg::SC_OK;
							end
						endcase
					end
				end
				S_TGT: begin
					if (tmul_q[0]) begin
						tgt_q <= tgt_q + mcand_q;
					end
					mcand_q <= {mcand_q[pali_pkg::PROD_W-2:0], 1'b0};
					tmul_q  <= tmul_q >> 1;
					cnt_q   <= cnt_q + 5'd1;
					if (cnt_q == 5'(pali_pkg::T_W - 1)) begin
						idx_q   <= '0;
						lst_q   <= '0;
						state_q <= S_RDA_W;
					end
				end
				S_RDA_W: begin
					state_q <= S_RDA;
				end
				S_RDA: begin
					a_q     <= rd_q;
					idx_q   <= pali_pkg::IDX_W'(1);
					state_q <= S_RDB_W;
				end
				S_RDB_W: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					b_q     <= rd_q;
					k_q     <= '0;
					acc_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					acc_q <= acc_q + prod[pali_pkg::RAD_W-1:0];
					k_q   <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						state_q <= S_SQRT_GO;
					end
				end
				S_SQRT_GO: begin
					state_q <= S_SQRT_W;
				end
				S_SQRT_W: begin
					if (sqrt_done) begin
						len_q   <= sqrt_root;
						state_q <= (op_q == pali_pkg::OP_ADD) ? S_ADDLEN : S_CHECK;
					end
				end
				S_ADDLEN: begin
					total_q <= sum_len[pali_pkg::LEN_W] ? '1 : sum_len[pali_pkg::LEN_W-1:0];
					state_q <= S_DONE;
				end
				S_CHECK: begin
					k_q <= '0;
					if (len_q == '0) begin
						status_q <= pali_pkg::SC_ZERO;
						state_q  <= S_DONE;
					end else if (reach >= pali_pkg::LST_W'(target)) begin
						if (num >= pali_pkg::LST_W'(len_q)) begin
							part_q  <= pali_pkg::T_ONE;
							state_q <= S_LERP;
						end else begin
							state_q <= S_DIV_GO;
						end
					end else begin
						lst_q <= lst_q + pali_pkg::LST_W'(len_q);
						a_q   <= b_q;
						if ((pali_pkg::CNT_W'(idx_q) + 1'b1) < count_q) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RDB_W;
						end else begin
							status_q <= pali_pkg::SC_NOMATCH;
							state_q  <= S_DONE;
						end
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_W;
				end
				S_DIV_W: begin
					if (div_done) begin
						part_q  <= {1'b0, div_q[15:0]};
						state_q <= S_LERP;
					end
				end
				S_LERP: begin
					pos_q[k_q] <= a_q[k_q] + rnd[31:0];
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_TAN_GO;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_TAN_GO: begin
					state_q <= S_TAN_W;
				end
				S_TAN_W: begin
					if (div_done) begin
						tan_q[k_q] <= tan_val;
						if (k_q == 2'd2) begin
							status_q <= pali_pkg::SC_OK;
							state_q  <= S_DONE;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_TAN_GO;
						end
					end
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		out_res             = '0;
		out_res.pos_x       = pos_q[0];
		out_res.pos_y       = pos_q[1];
		out_res.pos_z       = pos_q[2];
		out_res.tan_x       = tan_q[0];
		out_res.tan_y       = tan_q[1];
		out_res.tan_z       = tan_q[2];
		out_res.status      = status_q;
		out_res.point_total = 7'(count_q);
		out_res.path_length = total_q;
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	class path_scoreboard;
		logic signed [31:0] dflt_x, dflt_y, dflt_z;
		logic [15:0]        tol;
		logic signed [31:0] vx[pali_pkg::MAX_POINTS];
		logic signed [31:0] vy[pali_pkg::MAX_POINTS];
		logic signed [31:0] vz[pali_pkg::MAX_POINTS];
		int                 count;
		longint unsigned    total;
		pali_pkg::result_t  expected_results[$];
		int                 mismatches;

		function new();
			dflt_x = 0;
			dflt_y = 0;
			dflt_z = 0;
			tol = pali_pkg::TOL_RESET;
			count = 0;
			total = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [31:0] value);
			case (index)
				pali_pkg::REG_DEFAULT_X: dflt_x = value;
				pali_pkg::REG_DEFAULT_Y: dflt_y = value;
				pali_pkg::REG_DEFAULT_Z: dflt_z = value;
				pali_pkg::REG_TOLERANCE: tol = value[15:0];
				default: ;
			endcase
		endfunction

		function logic [33:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
			longint d;
			d = longint'(b) - longint'(a);
			if (d < 0)
				d = -d;
			return d[33:0];
		endfunction

		function longint unsigned seg_length(int i, int j);
			logic [71:0] sum, sq;
			logic [34:0] root, cand;
			sum = 72'(abs_diff(vx[i], vx[j])) * 72'(abs_diff(vx[i], vx[j]));
			sum = sum + 72'(abs_diff(vy[i], vy[j])) * 72'(abs_diff(vy[i], vy[j]));
			sum = sum + 72'(abs_diff(vz[i], vz[j])) * 72'(abs_diff(vz[i], vz[j]));
			root = 0;
			for (int b = 34; b >= 0; b--) begin
				cand = root | (35'd1 << b);
				sq = 72'(cand) * 72'(cand);
				if (sq <= sum)
					root = cand;
			end
			return longint'(root);
		endfunction

		function logic signed [31:0] lerp(logic signed [31:0] a, logic signed [31:0] b,
				longint part);
			longint prod;
			prod = (longint'(b) - longint'(a)) * part + 32768;
			return 32'(longint'(a) + (prod >>> 16));
		endfunction

		function logic signed [15:0] unit_tan(logic signed [31:0] a, logic signed [31:0] b,
				longint unsigned len);
			longint d;
			longint unsigned mag, q;
			d = longint'(b) - longint'(a);
			mag = d < 0 ? -d : d;
			q = (mag * 32768 + len / 2) / len;
			if (d < 0)
				return q > 32768 ? -16'sd32768 : 16'(-longint'(q));
			return q > 32767 ? 16'sd32767 : 16'(q);
		endfunction

		function void note_item(pali_pkg::op_t op, logic signed [31:0] x,
				logic signed [31:0] y, logic signed [31:0] z, logic signed [17:0] t);
			pali_pkg::result_t r;
			longint tc;
			longint unsigned target, lst, len, num;
			longint part;
			r.pos_x = dflt_x;
			r.pos_y = dflt_y;
			r.pos_z = dflt_z;
			r.tan_x = 0;
			r.tan_y = 0;
			r.tan_z = 0;
			r.status = pali_pkg::SC_OK;
			case (op)
				pali_pkg::OP_CLEAR: begin
					count = 0;
					total = 0;
				end
				pali_pkg::OP_ADD: begin
					if (count >= pali_pkg::MAX_POINTS) begin
						r.status = pali_pkg::SC_FULL;
					end else begin
						vx[count] = x;
						vy[count] = y;
						vz[count] = z;
						count++;
						if (count > 1) begin
							total += seg_length(count - 2, count - 1);
							if (total > 64'hFF_FFFF_FFFF)
								total = 64'hFF_FFFF_FFFF;
						end
					end
				end
				pali_pkg::OP_QUERY: begin
					tc = t;
					if (tc < 0)
						tc = 0;
					if (tc > 65536)
						tc = 65536;
					if (count < 2) begin
						r.status = pali_pkg::SC_FEW;
					end else begin
						target = (total * longint'(tc)) >> 16;
						lst = 0;
						r.status = pali_pkg::SC_NOMATCH;
						for (int i = 0; i + 1 < count; i++) begin
							len = seg_length(i, i + 1);
							if (len == 0) begin
								r.status = pali_pkg::SC_ZERO;
								break;
							end
							if (lst + len + tol >= target) begin
								num = target > lst ? target - lst : 0;
								part = num >= len ? 65536 : longint'((num << 16) / len);
								r.pos_x = lerp(vx[i], vx[i + 1], part);
								r.pos_y = lerp(vy[i], vy[i + 1], part);
								r.pos_z = lerp(vz[i], vz[i + 1], part);
								r.tan_x = unit_tan(vx[i], vx[i + 1], len);
								r.tan_y = unit_tan(vy[i], vy[i + 1], len);
								r.tan_z = unit_tan(vz[i], vz[i + 1], len);
								r.status = pali_pkg::SC_OK;
								break;
							end
							lst += len;
						end
					end
				end
				default: ;
			endcase
			r.point_total = 7'(count);
			r.path_length = total[39:0];
			expected_results = {expected_results, r};
		endfunction

		function void check_result(pali_pkg::result_t got);
			pali_pkg::result_t e;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transfer: %p", got);
				return;
			end
			e = expected_results.pop_front();
			if (got.pos_x !== e.pos_x || got.pos_y !== e.pos_y || got.pos_z !== e.pos_z ||
					got.tan_x !== e.tan_x || got.tan_y !== e.tan_y ||
					got.tan_z !== e.tan_z || got.status !== e.status ||
					got.point_total !== e.point_total ||
					got.path_length !== e.path_length) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result mismatch: expected %p, got %p", e, got);
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [119:0]  s_tdata;
	logic [1:0]    s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [191:0]  m_tdata;
	logic [2:0]    m_tuser;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [1:0]    cfg_index;
	logic [31:0]   cfg_data;

	path_scoreboard sb = new();
	int burst_left = 0;
	int items_sent = 0;

	polyline_arc_length_interpolator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#300000000;
		$display("simulation failed");
		$finish;
	end

	always @(negedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_item(pali_pkg::op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32],
				s_tdata[95:64], s_tdata[113:96]);
	end

	always @(negedge clk) begin
		pali_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pos_x = m_tdata[31:0];
			got.pos_y = m_tdata[63:32];
			got.pos_z = m_tdata[95:64];
			got.tan_x = m_tdata[111:96];
			got.tan_y = m_tdata[127:112];
			got.tan_z = m_tdata[143:128];
			got.point_total = m_tdata[150:144];
			got.path_length = m_tdata[190:151];
			got.status = pali_pkg::status_t'(m_tuser);
			sb.check_result(got);
		end
	end

	// The receiver switches at random among four stall patterns, and holds off
	// completely for one long stretch so that the block backs up onto its input.
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 400 == 0)
				mode = $urandom_range(0, 3);
			if (cyc >= 15000 && cyc < 15600)
				m_tready <= 1'b0;
			else if (mode == 0)
				m_tready <= 1'b1;
			else if (mode == 1)
				m_tready <= $urandom_range(0, 1);
			else if (mode == 2)
				m_tready <= ($urandom_range(0, 7) != 0);
			else
				m_tready <= ($urandom_range(0, 7) == 0);
		end
	end

	task automatic send_item(pali_pkg::op_t op, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic signed [17:0] t);
		int gap;
		bit acc;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, t, z, y, x};
		do begin
			@(negedge clk);
			acc = s_tready;
			@(posedge clk);
		end while (!acc);
		burst_left--;
		items_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [31:0] value);
		bit acc;
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		sb.write_reg(index, value);
	endtask

	task automatic set_config(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] tolerance);
		wait_idle();
		write_reg(pali_pkg::REG_DEFAULT_X, x);
		write_reg(pali_pkg::REG_DEFAULT_Y, y);
		write_reg(pali_pkg::REG_DEFAULT_Z, z);
		write_reg(pali_pkg::REG_TOLERANCE, {16'b0, tolerance});
	endtask

	function automatic logic signed [31:0] coord(int scale);
		if (scale == 0)
			return $signed(32'($urandom_range(0, 4095))) - 2048;
		if (scale == 1)
			return $signed(32'($urandom_range(0, 2097151))) - 1048576;
		return $urandom;
	endfunction

	task automatic random_phase(int quota);
		int goal;
		int npts, nq, scale;
		logic signed [31:0] x, y, z;
		logic signed [17:0] t;
		goal = items_sent + quota;
		while (items_sent < goal) begin
			if ($urandom_range(0, 99) < 85) begin
				send_item(pali_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
				npts = $urandom_range(0, 14) == 0 ? $urandom_range(60, 67)
					: $urandom_range(2, 8);
				scale = $urandom_range(0, 2);
				x = 0;
				y = 0;
				z = 0;
				for (int i = 0; i < npts; i++) begin
					if (i == 0 || $urandom_range(0, 39) != 0) begin
						x = coord(scale);
						y = coord(scale);
						z = coord(scale);
					end
					send_item(pali_pkg::OP_ADD, x, y, z, $urandom);
				end
				nq = $urandom_range(1, 5);
				for (int i = 0; i < nq; i++) begin
					if ($urandom_range(0, 5) == 0)
						t = $urandom;
					else
						t = $urandom_range(0, 65536);
					send_item(pali_pkg::OP_QUERY, $urandom, $urandom, $urandom, t);
				end
			end else begin
				send_item(pali_pkg::op_t'(2'($urandom_range(0, 3))), $urandom, $urandom,
					$urandom, $urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd32768);
		send_item(pali_pkg::OP_ADD, 32'sh10000, 0, 0, 0);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd65536);
		send_item(pali_pkg::OP_ADD, 32'sh10000, 0, 0, 0);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd0);
		send_item(pali_pkg::OP_CLEAR, 0, 0, 0, 0);
		send_item(pali_pkg::OP_ADD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
		send_item(pali_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
		send_item(pali_pkg::OP_ADD, 0, 0, 0, 0);
		send_item(pali_pkg::OP_ADD, 0, 32'sh30000, -32'sh40000, 0);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, -18'sd131072);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd131071);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd0);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd65536);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd32768);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd65535);
		send_item(pali_pkg::OP_NONE, -1, -1, -1, -1);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd1);

		set_config(32'h8000_0000, 32'h7FFF_FFFF, $urandom, 16'd0);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd49152);
		send_item(pali_pkg::OP_CLEAR, 0, 0, 0, 0);
		send_item(pali_pkg::OP_QUERY, 0, 0, 0, 18'sd49152);
		random_phase(250);

		set_config(32'h7FFF_FFFF, 32'h8000_0000, $urandom, 16'hFFFF);
		random_phase(250);

		set_config($urandom, $urandom, $urandom, $urandom);
		random_phase(250);

		set_config(0, 0, 0, pali_pkg::TOL_RESET);
		random_phase(250);

		wait_idle();
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
